>>> hdl/lsts_pkg.sv
// ============================================================================
// lsts_pkg : shared types, constants and table builders
// Word format passed from the front end to the back end, fixed field widths,
// and the elaboration-time builders for the exp2 and log2 tables.
// ============================================================================
package lsts_pkg;

    // Default parameter values
    localparam int unsigned VOCAB_MAX_DEF       = 65536;
    localparam int unsigned LOGIT_FRAC_BITS_DEF = 8;
    localparam int unsigned EXP_TABLE_DEPTH_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH         = 4;

    // Fixed field widths
    localparam int unsigned LOGIT_W   = 16;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned LOGPROB_W = 18;
    localparam int unsigned SUM_W     = 33;
    localparam int unsigned EXP_W     = 17;
    localparam int unsigned LOG_W     = 16;

    // Fixed-point constants
    localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
    localparam logic [15:0]       LN2_Q16   = 16'd45426;
    localparam longint unsigned   LN2_Q32   = 64'd2977044472;
    localparam logic [SUM_W-1:0]  SUM_LIMIT = {SUM_W{1'b1}};
    localparam logic [EXP_W-1:0]  ONE_Q16   = 17'd65536;
    localparam logic signed [LOGPROB_W-1:0] LP_MIN = 18'sh20000;

    // One classified logit word
    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic                      first;
        logic                      hit;
        logic                      last;
    } lsts_word_t;

    // Series term divide, one literal divisor per term
    function automatic longint unsigned div_step(longint unsigned t, int unsigned k);
        longint unsigned q;
        case (k)
            1:       q = t;
            2:       q = t / 2;
            3:       q = t / 3;
            4:       q = t / 4;
            5:       q = t / 5;
            6:       q = t / 6;
            7:       q = t / 7;
            8:       q = t / 8;
            9:       q = t / 9;
            10:      q = t / 10;
            11:      q = t / 11;
            12:      q = t / 12;
            13:      q = t / 13;
            14:      q = t / 14;
            15:      q = t / 15;
            16:      q = t / 16;
            17:      q = t / 17;
            18:      q = t / 18;
            19:      q = t / 19;
            20:      q = t / 20;
            21:      q = t / 21;
            22:      q = t / 22;
            23:      q = t / 23;
            default: q = t / 24;
        endcase
        return q;
    endfunction

    // 2^(-i/depth) in Q.16; x = i*ln2/depth in Q.32, 24-term series, round half up
    function automatic logic [EXP_W-1:0] exp_entry(longint unsigned x);
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned r;
        int unsigned     k;
        term = 64'd1 << 32;
        pos  = 64'd1 << 32;
        neg  = 64'd0;
        for (k = 1; k <= 24; k++) begin
            term = div_step((term * x) >> 32, k);
            if (k[0]) neg += term;
            else      pos += term;
        end
        r = ((pos - neg) + 64'd32768) >> 16;
        return r[EXP_W-1:0];
    endfunction

    // log2(1 + i/depth) in Q.16 by repeated squaring; v is 1 + i/depth in Q.30
    function automatic logic [LOG_W-1:0] log_entry(longint unsigned v0);
        longint unsigned v;
        logic [LOG_W-1:0] r;
        int unsigned      b;
        v = v0;
        r = '0;
        for (b = 16; b > 0; b--) begin
            v = (v * v) >> 30;
            if (v >= (64'd1 << 31)) begin
                v = v >> 1;
                r[b-1] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/log_softmax_token_scorer_top.sv
// ============================================================================
// log_softmax_token_scorer_top : streamed log-softmax score of one token
// The back end takes a new logit word only when idle: each word passes multiply,
// table read, exp and accumulate, with a rescale step when it raises the maximum,
// and a last word then holds it for normalise, ln table, ln and scoring. The
// result is registered, and result_valid rises once the output register is free.
// Reset: rst_n clears position, queue, sequencer and output valid.
// ============================================================================
module log_softmax_token_scorer_top #(
    parameter int unsigned VOCAB_MAX       = lsts_pkg::VOCAB_MAX_DEF,
    parameter int unsigned LOGIT_FRAC_BITS = lsts_pkg::LOGIT_FRAC_BITS_DEF,
    parameter int unsigned EXP_TABLE_DEPTH = lsts_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic signed [lsts_pkg::LOGIT_W-1:0]    logit,
    input  logic [lsts_pkg::INDEX_W-1:0]           target_index,
    input  logic                                   last,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [lsts_pkg::LOGPROB_W-1:0]  log_probability,
    output logic                                   target_found
);
    import lsts_pkg::*;

    lsts_word_t front_word;
    lsts_word_t back_word;
    logic       front_valid;
    logic       front_ready;
    logic       back_valid;
    logic       back_ready;

    // Front end: position tracking and target match
    lsts_front #(
        .VOCAB_MAX (VOCAB_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .logit        (logit),
        .target_index (target_index),
        .last         (last),
        .word_valid   (front_valid),
        .word_ready   (front_ready),
        .word         (front_word)
    );

    // Decoupling queue
    lsts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_word   (back_word)
    );

    // Back end: accumulation and scoring
    lsts_back #(
        .LOGIT_FRAC_BITS (LOGIT_FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .word_valid      (back_valid),
        .word_ready      (back_ready),
        .word            (back_word),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .log_probability (log_probability),
        .target_found    (target_found)
    );

endmodule

>>> hdl/lsts_front.sv
// ============================================================================
// lsts_front : input stage
// Accepts logit words, tracks the element position, latches the target index
// on the first element and marks the word that sits at the target position.
// ============================================================================
module lsts_front #(
    parameter int unsigned VOCAB_MAX = 65536
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic signed [lsts_pkg::LOGIT_W-1:0]  logit,
    input  logic [lsts_pkg::INDEX_W-1:0]         target_index,
    input  logic                                 last,
    output logic                                 word_valid,
    input  logic                                 word_ready,
    output lsts_pkg::lsts_word_t                 word
);
    import lsts_pkg::*;

    localparam int unsigned POS_W = $clog2(VOCAB_MAX + 1);
    localparam int unsigned CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;

    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   position_next;
    logic [INDEX_W-1:0] target_reg;
    logic [INDEX_W-1:0] target_next;
    logic [INDEX_W-1:0] target_cur;
    logic               first;
    logic               in_range;
    logic               accept;

    assign item_ready = word_ready;
    assign word_valid = item_valid;
    assign accept     = item_valid & word_ready;

    // Classification of the current word
    assign first      = (position_reg == '0);
    assign target_cur = first ? target_index : target_reg;
    assign in_range   = (position_reg < POS_W'(VOCAB_MAX));

    always_comb
    begin
        word.logit = logit;
        word.first = first;
        word.hit   = in_range && (CMP_W'(position_reg) == CMP_W'(target_cur));
        word.last  = last;
    end

    // Position counter: saturates at VOCAB_MAX, restarts after the last word
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        if (accept) begin
            target_next = target_cur;
            if (last)
                position_next = '0;
            else if (in_range)
                position_next = position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_reg <= '0;
        else
            position_reg <= position_next;
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
    end

endmodule

>>> hdl/lsts_queue.sv
// ============================================================================
// lsts_queue : word queue
// Small register FIFO between the front end and the back end.
// ============================================================================
module lsts_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lsts_pkg::lsts_word_t push_word,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output lsts_pkg::lsts_word_t pop_word
);
    import lsts_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lsts_word_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

>>> hdl/lsts_back.sv
// ============================================================================
// lsts_back : accumulation and scoring sequencer
// Per word: running maximum, one exp evaluation, rescale or add into the
// saturating sum. On the last word: normalise the sum, ln by table, score.
// ============================================================================
module lsts_back #(
    parameter int unsigned LOGIT_FRAC_BITS = 8,
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   word_valid,
    output logic                                   word_ready,
    input  lsts_pkg::lsts_word_t                   word,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [lsts_pkg::LOGPROB_W-1:0]  log_probability,
    output logic                                   target_found
);
    import lsts_pkg::*;

    localparam int unsigned TAB_W = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int unsigned LN_W  = LOGIT_FRAC_BITS + 6;
    localparam int unsigned LP_WW = ((LN_W > 17) ? LN_W : 17) + 2;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_MUL  = 13'b0000000000010,
        S_ROM  = 13'b0000000000100,
        S_EXP  = 13'b0000000001000,
        S_ACC1 = 13'b0000000010000,
        S_ACC2 = 13'b0000000100000,
        S_LOAD = 13'b0000001000000,
        S_NORM = 13'b0000010000000,
        S_LTAB = 13'b0000100000000,
        S_LN   = 13'b0001000000000,
        S_OUT  = 13'b0010000000000,
        S_SPR1 = 13'b0100000000000,
        S_SPR2 = 13'b1000000000000
    } lsts_state_t;

    // Constant tables, built at elaboration
    logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    logic [LOG_W-1:0] log_rom [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
        localparam longint unsigned XG = (64'(g) * LN2_Q32) / EXP_TABLE_DEPTH;
        localparam longint unsigned VG = (64'd1 << 30) + ((64'(g) << 30) / EXP_TABLE_DEPTH);
        assign exp_rom[g] = exp_entry(XG);
        assign log_rom[g] = log_entry(VG);
    end

    lsts_state_t               state_reg, state_next;
    logic                      res_valid_reg, res_valid_next;
    logic signed [LOGPROB_W-1:0] res_lp_reg, res_lp_next;
    logic                      res_found_reg, res_found_next;

    logic                      last_reg, last_next;
    logic                      grow_reg, grow_next;
    logic [15:0]               d_reg, d_next;
    logic signed [LOGIT_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic signed [LOGIT_W-1:0] cap_logit_reg, cap_logit_next;
    logic                      cap_flag_reg, cap_flag_next;
    logic [32:0]               y_reg, y_next;
    logic [EXP_W-1:0]          exp_rd_reg, exp_rd_next;
    logic                      exp_zero_reg, exp_zero_next;
    logic [4:0]                exp_shift_reg, exp_shift_next;
    logic [EXP_W-1:0]          e_reg, e_next;
    logic [33:0]               p_lo_reg, p_lo_next;
    logic [SUM_W-1:0]          norm_reg, norm_next;
    logic [5:0]                n_cnt_reg, n_cnt_next;
    logic [2:0]                step_reg, step_next;
    logic                      sum_zero_reg, sum_zero_next;
    logic [LOG_W-1:0]          lt_reg, lt_next;
    logic [LN_W-1:0]           ln_reg, ln_next;

    // Datapath temporaries
    logic signed [LOGIT_W-1:0] base_max;
    logic signed [16:0]        diff;
    logic [16:0]               neg_diff;
    logic [32:0]               scaled;
    logic [31:0]               idx_prod;
    logic [TAB_W-1:0]          idx;
    logic [33:0]               sum_add;
    logic [32:0]               p_hi;
    logic [34:0]               acc;
    logic [47:0]               j_prod;
    logic [TAB_W-1:0]          j_idx;
    logic [5:0]                n_less;
    logic [20:0]               l2;
    logic [37:0]               ln_prod;
    logic signed [LP_WW-1:0]   lp_wide;
    logic                      out_free;

    assign word_ready      = (state_reg == S_IDLE);
    assign result_valid    = res_valid_reg;
    assign log_probability = res_lp_reg;
    assign target_found    = res_found_reg;
    assign out_free        = !res_valid_reg || result_ready;

    // Difference against the running maximum
    assign base_max = word.first ? word.logit : max_reg;
    assign diff     = 17'(word.logit) - 17'(base_max);
    assign neg_diff = -diff;

    // exp(-d): split d*log2(e) into shift and table index
    assign scaled   = y_reg >> LOGIT_FRAC_BITS;
    assign idx_prod = 32'(scaled[15:0]) * 32'(EXP_TABLE_DEPTH);
    assign idx      = idx_prod[16 +: TAB_W];

    // Sum update paths
    assign sum_add  = 34'(sum_reg) + 34'(e_reg);
    assign p_hi     = 33'(sum_reg[32:17]) * 33'(e_reg);
    assign acc      = (35'(p_hi) << 1) + 35'(p_lo_reg >> 16) + 35'(ONE_Q16);

    // ln of the normalised sum
    assign j_prod   = 48'(norm_reg[31:0]) * 48'(EXP_TABLE_DEPTH);
    assign j_idx    = j_prod[32 +: TAB_W];
    assign n_less   = n_cnt_reg - 6'd16;
    assign l2       = (n_cnt_reg < 6'd16) ? 21'd0 : {n_less[4:0], lt_reg};
    assign ln_prod  = 38'(l2) * 38'(LN2_Q16) + (38'd1 << (31 - LOGIT_FRAC_BITS));

    // Score before clamping
    assign lp_wide  = LP_WW'(cap_logit_reg) - LP_WW'(max_reg) - LP_WW'({1'b0, ln_reg});

    always_comb
    begin
        state_next      = state_reg;
        res_valid_next  = res_valid_reg;
        res_lp_next     = res_lp_reg;
        res_found_next  = res_found_reg;
        last_next       = last_reg;
        grow_next       = grow_reg;
        d_next          = d_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        cap_logit_next  = cap_logit_reg;
        cap_flag_next   = cap_flag_reg;
        y_next          = y_reg;
        exp_rd_next     = exp_rd_reg;
        exp_zero_next   = exp_zero_reg;
        exp_shift_next  = exp_shift_reg;
        e_next          = e_reg;
        p_lo_next       = p_lo_reg;
        norm_next       = norm_reg;
        n_cnt_next      = n_cnt_reg;
        step_next       = step_reg;
        sum_zero_next   = sum_zero_reg;
        lt_next         = lt_reg;
        ln_next         = ln_reg;

        if (res_valid_reg && result_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            // Take a word, update maximum and capture
            S_IDLE:
            begin
                if (word_valid) begin
                    last_next = word.last;
                    grow_next = !diff[16] && (diff != '0);
                    d_next    = diff[16] ? neg_diff[15:0] : diff[15:0];
                    max_next  = (!diff[16] && (diff != '0)) ? word.logit : base_max;
                    if (word.first) begin
                        sum_next       = '0;
                        cap_flag_next  = 1'b0;
                        cap_logit_next = '0;
                    end
                    if (word.hit) begin
                        cap_flag_next  = 1'b1;
                        cap_logit_next = word.logit;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                y_next     = 33'(d_reg) * 33'(LOG2E_Q16);
                state_next = S_ROM;
            end
            S_ROM:
            begin
                exp_rd_next    = exp_rom[idx];
                exp_zero_next  = (scaled[32:16] >= 17'd17);
                exp_shift_next = scaled[20:16];
                state_next     = S_EXP;
            end
            S_EXP:
            begin
                e_next     = exp_zero_reg ? '0 : (exp_rd_reg >> exp_shift_reg);
                state_next = S_ACC1;
            end
            // Plain add, or first half of the rescale product
            S_ACC1:
            begin
                if (grow_reg) begin
                    p_lo_next  = 34'(sum_reg[16:0]) * 34'(e_reg);
                    state_next = S_ACC2;
                end else begin
                    sum_next   = (sum_add > 34'(SUM_LIMIT)) ? SUM_LIMIT : sum_add[SUM_W-1:0];
                    state_next = last_reg ? S_LOAD : S_IDLE;
                end
            end
            // Rescaled sum plus exp(0)
            S_ACC2:
            begin
                sum_next   = (acc > 35'(SUM_LIMIT)) ? SUM_LIMIT : acc[SUM_W-1:0];
                state_next = last_reg ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                norm_next     = sum_reg;
                n_cnt_next    = 6'd32;
                step_next     = '0;
                sum_zero_next = (sum_reg == '0);
                state_next    = S_NORM;
            end
            // Leading-zero search, halving the shift each step down to one bit, tried twice
            S_NORM:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        if (norm_reg[32:17] == '0) begin
                            norm_next  = norm_reg << 16;
                            n_cnt_next = n_cnt_reg - 6'd16;
                        end
                    end
                    3'd1:
                    begin
                        if (norm_reg[32:25] == '0) begin
                            norm_next  = norm_reg << 8;
                            n_cnt_next = n_cnt_reg - 6'd8;
                        end
                    end
                    3'd2:
                    begin
                        if (norm_reg[32:29] == '0) begin
                            norm_next  = norm_reg << 4;
                            n_cnt_next = n_cnt_reg - 6'd4;
                        end
                    end
                    3'd3:
                    begin
                        if (norm_reg[32:31] == '0) begin
                            norm_next  = norm_reg << 2;
                            n_cnt_next = n_cnt_reg - 6'd2;
                        end
                    end
                    default:
                    begin
                        if (!norm_reg[32] && (n_cnt_reg != '0)) begin
                            norm_next  = norm_reg << 1;
                            n_cnt_next = n_cnt_reg - 6'd1;
                        end
                    end
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                    state_next = S_LTAB;
            end
            S_LTAB:
            begin
                lt_next    = log_rom[j_idx];
                state_next = S_LN;
            end
            S_LN:
            begin
                ln_next    = sum_zero_reg ? '0 : LN_W'(ln_prod >> (32 - LOGIT_FRAC_BITS));
                state_next = S_OUT;
            end
            // Clamp and hand to the output register
            S_OUT:
            begin
                if (out_free) begin
                    res_valid_next = 1'b1;
                    res_found_next = cap_flag_reg;
                    if (!cap_flag_reg || (lp_wide > 0))
                        res_lp_next = '0;
                    else if (lp_wide < LP_WW'(LP_MIN))
                        res_lp_next = LP_MIN;
                    else
                        res_lp_next = lp_wide[LOGPROB_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_lp_reg    <= res_lp_next;
        res_found_reg <= res_found_next;
        last_reg      <= last_next;
        grow_reg      <= grow_next;
        d_reg         <= d_next;
        max_reg       <= max_next;
        sum_reg       <= sum_next;
        cap_logit_reg <= cap_logit_next;
        cap_flag_reg  <= cap_flag_next;
        y_reg         <= y_next;
        exp_rd_reg    <= exp_rd_next;
        exp_zero_reg  <= exp_zero_next;
        exp_shift_reg <= exp_shift_next;
        e_reg         <= e_next;
        p_lo_reg      <= p_lo_next;
        norm_reg      <= norm_next;
        n_cnt_reg     <= n_cnt_next;
        step_reg      <= step_next;
        sum_zero_reg  <= sum_zero_next;
        lt_reg        <= lt_next;
        ln_reg        <= ln_next;
    end

endmodule
